// File: src/eos_pkg.sv
// ----------------------------------------------------------------------------
// eos_pkg
// Shared widths, codes, types and decision functions of the elevator order
// scheduler: SCAN direction rule, served-order clear mask and stop test.
// ----------------------------------------------------------------------------
package eos_pkg;

  localparam int unsigned FLOORS_DEF = 4;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned FLOOR_W = 2;
  localparam int unsigned BTN_W   = 2;
  localparam int unsigned DIR_W   = 2;
  localparam int unsigned FLAG_W  = 3;

  localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SET   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DIR   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SERVE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QUERY = 3'd5;

  localparam logic [BTN_W-1:0] BTN_UP   = 2'd0;
  localparam logic [BTN_W-1:0] BTN_DOWN = 2'd1;
  localparam logic [BTN_W-1:0] BTN_CMD  = 2'd2;

  localparam logic [FLAG_W-1:0] FLAG_UP   = 3'b001;
  localparam logic [FLAG_W-1:0] FLAG_DOWN = 3'b010;
  localparam logic [FLAG_W-1:0] FLAG_CMD  = 3'b100;

  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 2'b00,
    DIR_UP   = 2'b01,
    DIR_DOWN = 2'b11
  } dir_e;

  typedef struct packed {
    logic              below;
    logic              above;
    logic [FLAG_W-1:0] here;
  } scan_res_t;

  function automatic dir_e sensed_dir(dir_e dir, scan_res_t r);
    dir_e nd;
    nd = DIR_STOP;
    if (!r.below && !r.above && (r.here == '0)) begin
      nd = DIR_STOP;
    end else if (dir == DIR_UP) begin
      nd = r.above ? DIR_UP : DIR_DOWN;
    end else if (dir == DIR_DOWN) begin
      nd = r.below ? DIR_DOWN : DIR_UP;
    end else if (r.here != '0) begin
      if (r.below) begin
        nd = DIR_DOWN;
      end else if (r.above) begin
        nd = DIR_UP;
      end else begin
        nd = DIR_STOP;
      end
    end else begin
      nd = r.below ? DIR_DOWN : DIR_UP;
    end
    return nd;
  endfunction

  function automatic logic [FLAG_W-1:0] clear_mask(dir_e dir, scan_res_t r);
    logic [FLAG_W-1:0] m;
    m = '0;
    if (dir == DIR_UP) begin
      m = FLAG_UP | FLAG_CMD | (r.above ? '0 : FLAG_DOWN);
    end else if (dir == DIR_DOWN) begin
      m = FLAG_DOWN | FLAG_CMD | (r.below ? '0 : FLAG_UP);
    end else begin
      if (r.below) begin
        m = FLAG_DOWN | FLAG_CMD;
      end else if (r.above) begin
        m = FLAG_UP | FLAG_CMD;
      end else begin
        m = FLAG_UP | FLAG_DOWN | FLAG_CMD;
      end
    end
    return m;
  endfunction

  function automatic logic stop_hit(dir_e dir, scan_res_t r);
    logic s;
    s = 1'b1;
    if (dir == DIR_UP) begin
      s = ((r.here & (FLAG_UP | FLAG_CMD)) != '0) || !r.above;
    end else if (dir == DIR_DOWN) begin
      s = ((r.here & (FLAG_DOWN | FLAG_CMD)) != '0) || !r.below;
    end
    return s;
  endfunction

endpackage

// File: src/eos_in_if.sv
// ----------------------------------------------------------------------------
// eos_in_if
// Command channel of the order scheduler: valid, ready and one command beat.
// ----------------------------------------------------------------------------
interface eos_in_if;
  import eos_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [FLOOR_W-1:0] floor;
  logic [BTN_W-1:0]   button;
  logic               at_floor;

  modport source (output valid, output mode, output floor, output button,
                  output at_floor, input ready);
  modport sink   (input valid, input mode, input floor, input button,
                  input at_floor, output ready);
endinterface

// File: src/eos_out_if.sv
// ----------------------------------------------------------------------------
// eos_out_if
// Status channel of the order scheduler: valid, ready and one status beat.
// ----------------------------------------------------------------------------
interface eos_out_if;
  import eos_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DIR_W-1:0]  motor_dir;
  logic                     should_stop;
  logic [FLOOR_W-1:0]       car_floor;

  modport source (output valid, output motor_dir, output should_stop,
                  output car_floor, input ready);
  modport sink   (input valid, input motor_dir, input should_stop,
                  input car_floor, output ready);
endinterface

// File: src/eos_store.sv
// ----------------------------------------------------------------------------
// eos_store
// Order table: one flag word per floor in a memory, a valid bit per floor
// that reset and clear-all drop at once, one write and one registered read.
// ----------------------------------------------------------------------------
module eos_store #(
  parameter int unsigned Floors = eos_pkg::FLOORS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clr_i,
  input  logic                       wr_en_i,
  input  logic [$clog2(Floors)-1:0]  wr_addr_i,
  input  logic [eos_pkg::FLAG_W-1:0] wr_flags_i,
  input  logic [$clog2(Floors)-1:0]  rd_addr_i,
  output logic [eos_pkg::FLAG_W-1:0] rd_flags_o
);
  import eos_pkg::*;

  logic [FLAG_W-1:0] mem_q [Floors];
  logic [Floors-1:0] vld_q;
  logic [FLAG_W-1:0] rd_data_q;
  logic              rd_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_flags_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
    rd_hit_q  <= vld_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_i) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // an entry never written since the last clear reads as empty
  assign rd_flags_o = rd_hit_q ? rd_data_q : '0;

endmodule

// File: src/eos_scan.sv
// ----------------------------------------------------------------------------
// eos_scan
// Floor scanner: walks the order table one floor a cycle and collects
// orders below and above the car and the flags at the car's floor.
// ----------------------------------------------------------------------------
module eos_scan #(
  parameter int unsigned Floors = eos_pkg::FLOORS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [$clog2(Floors)-1:0]  lvl_i,
  input  logic [eos_pkg::FLAG_W-1:0] rd_flags_i,
  output logic [$clog2(Floors)-1:0]  rd_addr_o,
  output logic                       done_o,
  output eos_pkg::scan_res_t         res_o
);
  import eos_pkg::*;

  localparam int unsigned IdxW = $clog2(Floors);
  localparam int unsigned CntW = $clog2(Floors + 1);
  localparam logic [IdxW-1:0] Last = IdxW'(Floors - 1);

  logic              busy_q;
  logic [CntW-1:0]   cnt_q;
  logic              tap_vld_q;
  logic [IdxW-1:0]   tap_idx_q;
  logic              done_q;
  logic              below_q;
  logic              above_q;
  logic [FLAG_W-1:0] here_q;
  logic              issue;

  assign issue     = busy_q && (cnt_q < CntW'(Floors));
  assign rd_addr_o = issue ? cnt_q[IdxW-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cnt_q     <= '0;
      tap_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      done_q <= tap_vld_q && (tap_idx_q == Last);
      if (start_i) begin
        busy_q    <= 1'b1;
        cnt_q     <= '0;
        tap_vld_q <= 1'b0;
      end else begin
        tap_vld_q <= issue;
        if (issue) begin
          cnt_q <= cnt_q + 1'b1;
        end else begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tap_idx_q <= cnt_q[IdxW-1:0];
    if (start_i) begin
      below_q <= 1'b0;
      above_q <= 1'b0;
      here_q  <= '0;
    end else if (tap_vld_q) begin
      if (tap_idx_q < lvl_i) begin
        below_q <= below_q | (rd_flags_i != '0);
      end
      if (tap_idx_q > lvl_i) begin
        above_q <= above_q | (rd_flags_i != '0);
      end
      if (tap_idx_q == lvl_i) begin
        here_q <= rd_flags_i;
      end
    end
  end

  assign done_o      = done_q;
  assign res_o.below = below_q;
  assign res_o.above = above_q;
  assign res_o.here  = here_q;

endmodule

// File: src/elevator_order_scheduler_core.sv
// ----------------------------------------------------------------------------
// elevator_order_scheduler_core
// SCAN elevator scheduler: keeps the order table, the car floor and the
// travel direction, and answers every command beat with one status beat.
//
//   channel  dir  handshake       payload
//   in_if    in   valid / ready   mode, floor, button, at_floor
//   out_if   out  valid / ready   motor_dir, should_stop, car_floor
//
// each floor scan walks the table through the shared scanner;
// a beat needs one scan, mode 3 two and mode 4 three, and an added order
// first reads and rewrites its table entry before its scan.
// one beat at a time: in_if.ready is high only while the sequencer idles.
// a status beat waits in the output register; a stalled out_if holds only
// the next result. reset clears the table at once, no clearing pass.
// ----------------------------------------------------------------------------
module elevator_order_scheduler_core #(
  parameter int unsigned Floors = eos_pkg::FLOORS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  eos_in_if.sink    in_if,
  eos_out_if.source out_if
);
  import eos_pkg::*;

  localparam int unsigned IdxW = $clog2(Floors);
  localparam logic [IdxW-1:0] Last = IdxW'(Floors - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ORD_RD = 3'd1;
  localparam logic [2:0] ST_ORD_WR = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  localparam logic [1:0] STEP_DIR = 2'd0;
  localparam logic [1:0] STEP_CLR = 2'd1;
  localparam logic [1:0] STEP_FIN = 2'd2;

  logic [2:0]         state_q, state_d;
  logic [1:0]         step_q, step_d;
  logic [MODE_W-1:0]  mode_q;
  logic [FLOOR_W-1:0] fl_q;
  logic [BTN_W-1:0]   btn_q;
  logic               sensed_q;
  logic [IdxW-1:0]    lvl_q, lvl_d;
  dir_e               dir_q, dir_d;
  logic               out_vld_q;
  logic [DIR_W-1:0]   out_dir_q;
  logic               out_stop_q;
  logic [FLOOR_W-1:0] out_floor_q;

  logic              accept;
  logic              order_ok;
  logic              scan_start;
  logic              scan_done;
  scan_res_t         res;
  logic [IdxW-1:0]   scan_addr;
  logic [IdxW-1:0]   ord_addr;
  logic [IdxW-1:0]   rd_addr;
  logic [FLAG_W-1:0] rd_flags;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  logic [FLAG_W-1:0] wr_flags;
  logic              clr_all;
  logic              out_load;
  dir_e              dir_nx;
  logic [IdxW-1:0]   lvl_nx;

  assign in_if.ready = (state_q == ST_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign order_ok    = (32'(in_if.floor) < Floors) &&
                       (in_if.button inside {BTN_UP, BTN_DOWN, BTN_CMD});
  assign clr_all     = accept && (in_if.mode == MODE_CLEAR);
  assign ord_addr    = IdxW'(fl_q);
  assign rd_addr     = (state_q == ST_ORD_RD) ? ord_addr : scan_addr;

  assign wr_en    = (state_q == ST_ORD_WR) ||
                    ((state_q == ST_SCAN) && scan_done && (step_q == STEP_CLR));
  assign wr_addr  = (state_q == ST_ORD_WR) ? ord_addr : lvl_q;
  assign wr_flags = (state_q == ST_ORD_WR) ? (rd_flags | (FLAG_UP << btn_q))
                                           : (res.here & ~clear_mask(dir_q, res));

  eos_store #(
    .Floors (Floors)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (clr_all),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_flags_i (wr_flags),
    .rd_addr_i  (rd_addr),
    .rd_flags_o (rd_flags)
  );

  eos_scan #(
    .Floors (Floors)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scan_start),
    .lvl_i      (lvl_q),
    .rd_flags_i (rd_flags),
    .rd_addr_o  (scan_addr),
    .done_o     (scan_done),
    .res_o      (res)
  );

  // direction step, with the floor nudge when between floors
  always_comb begin
    dir_nx = dir_q;
    lvl_nx = lvl_q;
    if (sensed_q) begin
      dir_nx = sensed_dir(dir_q, res);
    end else if ((dir_q == DIR_UP) && !res.above) begin
      if (lvl_q != Last) begin
        lvl_nx = lvl_q + 1'b1;
      end
      dir_nx = DIR_DOWN;
    end else if ((dir_q == DIR_DOWN) && !res.below) begin
      if (lvl_q != '0) begin
        lvl_nx = lvl_q - 1'b1;
      end
      dir_nx = DIR_UP;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    lvl_d      = lvl_q;
    dir_d      = dir_q;
    scan_start = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d    = ST_SCAN;
          step_d     = STEP_FIN;
          scan_start = 1'b1;
          case (in_if.mode)
            MODE_ADD: begin
              if (order_ok) begin
                state_d    = ST_ORD_RD;
                scan_start = 1'b0;
              end
            end
            MODE_SET: begin
              if (in_if.at_floor && (32'(in_if.floor) < Floors)) begin
                lvl_d = IdxW'(in_if.floor);
              end
            end
            MODE_DIR, MODE_SERVE: begin
              step_d = STEP_DIR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ORD_RD: begin
        state_d = ST_ORD_WR;
      end
      ST_ORD_WR: begin
        state_d    = ST_SCAN;
        step_d     = STEP_FIN;
        scan_start = 1'b1;
      end
      ST_SCAN: begin
        if (scan_done) begin
          case (step_q)
            STEP_DIR: begin
              dir_d      = dir_nx;
              lvl_d      = lvl_nx;
              step_d     = (mode_q == MODE_SERVE) ? STEP_CLR : STEP_FIN;
              scan_start = 1'b1;
            end
            STEP_CLR: begin
              step_d     = STEP_FIN;
              scan_start = 1'b1;
            end
            default: begin
              state_d = ST_OUT;
            end
          endcase
        end
      end
      ST_OUT: begin
        if (!out_vld_q || out_if.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= STEP_FIN;
      lvl_q     <= '0;
      dir_q     <= DIR_STOP;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      lvl_q   <= lvl_d;
      dir_q   <= dir_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= in_if.mode;
      fl_q     <= in_if.floor;
      btn_q    <= in_if.button;
      sensed_q <= in_if.at_floor;
    end
    if (out_load) begin
      out_dir_q   <= dir_q;
      out_stop_q  <= stop_hit(dir_q, res);
      out_floor_q <= FLOOR_W'(lvl_q);
    end
  end

  assign out_if.valid       = out_vld_q;
  assign out_if.motor_dir   = $signed(out_dir_q);
  assign out_if.should_stop = out_stop_q;
  assign out_if.car_floor   = out_floor_q;

endmodule

// File: src/eos_checker.sv
// ----------------------------------------------------------------------------
// eos_checker
// Port-level checks of the order scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module eos_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] motor_dir_i,
  input logic       should_stop_i,
  input logic [1:0] car_floor_i
);
  import eos_pkg::*;

  // one command in flight: busy right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready high right after an accepted beat");

  a_dir_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (motor_dir_i != 2'b10))
    else $error("illegal motor direction code");

  a_stop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (motor_dir_i == DIR_STOP) |-> should_stop_i)
    else $error("stopped car without stop flag");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable({motor_dir_i, should_stop_i, car_floor_i}))
    else $error("stalled status beat changed");

endmodule

bind elevator_order_scheduler_core eos_checker u_eos_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .motor_dir_i   (out_if.motor_dir),
  .should_stop_i (out_if.should_stop),
  .car_floor_i   (out_if.car_floor)
);
